@@ rtl/core/adaptive_focus_score_tracker_assert.svh @@
// Assertion macros for the focus score tracker checker.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef ADAPTIVE_FOCUS_SCORE_TRACKER_ASSERT_SVH
`define ADAPTIVE_FOCUS_SCORE_TRACKER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define AFST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent
`define AFST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/afst_pkg.sv @@
// Package for the adaptive focus score tracker: widths, register indexes,
// mode codes and sequencer states. No dependencies.
package afst_pkg;

  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned SCORE_W = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PROD_W = ALPHA_W + SAMPLE_W;
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned SUM_W = 33;

  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [SAMPLE_W-1:0] ONE_Q8 = 24'd256;

  localparam logic [ALPHA_W-1:0] BOUNDS_ALPHA_RST = 17'd3277;
  localparam logic [ALPHA_W-1:0] EWM_ALPHA_RST = 17'd13107;
  localparam logic [SAMPLE_W-1:0] SHARP_START_RST = 24'd5120;
  localparam logic [SAMPLE_W-1:0] BLUR_START_RST = 24'd512;

  localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_ALPHA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EWM_ALPHA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHARP_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_START = 3'd3;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_DECAY  = 2'd1,
    MODE_RESET  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_SHARP = 10'b00_0000_0010,
    ST_BLUR  = 10'b00_0000_0100,
    ST_APPLY = 10'b00_0000_1000,
    ST_PREP  = 10'b00_0001_0000,
    ST_DIV   = 10'b00_0010_0000,
    ST_MIX1  = 10'b00_0100_0000,
    ST_MIX2  = 10'b00_1000_0000,
    ST_MIX3  = 10'b01_0000_0000,
    ST_OUT   = 10'b10_0000_0000
  } state_t;

endpackage

@@ rtl/core/afst_if.sv @@
// Valid/ready channel interfaces for the focus score tracker.
// Depends on afst_pkg for field widths.
interface afst_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic [afst_pkg::SAMPLE_W-1:0]     lap_std;

  modport source (output valid, output mode, output lap_std, input ready);
  modport sink (input valid, input mode, input lap_std, output ready);
endinterface

interface afst_out_if;
  logic                              valid;
  logic                              ready;
  logic [afst_pkg::SCORE_W-1:0]      score;

  modport source (output valid, output score, input ready);
  modport sink (input valid, input score, output ready);
endinterface

@@ rtl/core/adaptive_focus_score_tracker.sv @@
// Adaptive focus score tracker: adaptive bounds, serial divider, EWMA score.
// Depends on afst_pkg and the channel interfaces in afst_if.sv.
//
// Usage: one transfer on in_ch per frame carries a mode and a sharpness sample
// (Q16.8). Every accepted item gives exactly one transfer on out_ch with the
// smoothed focus score (Q1.16, 65536 is fully sharp).
// Weights and start bounds are written through cfg_we/cfg_index/cfg_wdata;
// start bounds take effect at the next reset command; rst restores the defaults.
// Work is done by one shared 17x24 multiplier with a registered product and a
// restoring divider that retires one quotient bit a cycle, under a sequencer.
// An update runs two bound products, range set-up, 16 divide steps, two score
// products and one sum; it skips the divide steps when the sample is at or below
// the blur bound or past the full range. Decay runs one score product and the sum;
// reset and unused mode go straight to the result.
// One item at a time: in_ch.ready is high only while the sequencer is idle,
// so an item occupies the block until its score is loaded into the result register.
// The result sits in an output register; while the receiver stalls the next
// item may be taken and worked on, and its result waits until the register
// frees. rst (synchronous) reloads registers, bounds and clears the score.
module adaptive_focus_score_tracker (
  input  logic                            clk,
  input  logic                            rst,
  afst_in_if.sink                         in_ch,
  afst_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [afst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afst_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [afst_pkg::ALPHA_W-1:0]  bounds_alpha;
  logic [afst_pkg::ALPHA_W-1:0]  ewm_alpha;
  logic [afst_pkg::SAMPLE_W-1:0] sharp_start;
  logic [afst_pkg::SAMPLE_W-1:0] blur_start;

  // Tracker state
  logic [afst_pkg::SAMPLE_W-1:0] sharp_bound;
  logic [afst_pkg::SAMPLE_W-1:0] blur_bound;
  logic [afst_pkg::SCORE_W-1:0]  smoothed_score;

  // Item being worked on
  afst_pkg::state_t              state;
  logic                          is_update;
  logic [afst_pkg::SAMPLE_W-1:0] sample;
  logic [afst_pkg::ALPHA_W-1:0]  ba;
  logic [afst_pkg::ALPHA_W-1:0]  ea;

  // Shared multiplier and divider
  logic [afst_pkg::ALPHA_W-1:0]  mul_a;
  logic [afst_pkg::SAMPLE_W-1:0] mul_b;
  logic [afst_pkg::PROD_W-1:0]   prod;
  logic [afst_pkg::SUM_W-1:0]    acc;
  logic [afst_pkg::SUM_W-1:0]    mix_sum;
  logic [afst_pkg::SAMPLE_W-1:0] range;
  logic [afst_pkg::SAMPLE_W-1:0] rem;
  logic [afst_pkg::SAMPLE_W-1:0] rem_next;
  logic [afst_pkg::SAMPLE_W:0]   rem_sh;
  logic                          rem_ge;
  logic [afst_pkg::QUOT_W-1:0]   quot;
  logic [3:0]                    div_cnt;
  logic [afst_pkg::SCORE_W-1:0]  raw;

  // Range set-up values
  logic [afst_pkg::SAMPLE_W:0]   span;
  logic [afst_pkg::SAMPLE_W-1:0] range_next;
  logic [afst_pkg::SAMPLE_W-1:0] num;

  // Result register
  logic                          res_valid;
  logic [afst_pkg::SCORE_W-1:0]  res_score;
  logic                          res_load;

  // Saturated weights at item start
  logic [afst_pkg::ALPHA_W-1:0]  ba_sat;
  logic [afst_pkg::ALPHA_W-1:0]  ea_sat;

  assign ba_sat = (bounds_alpha > afst_pkg::ONE_Q16) ? afst_pkg::ONE_Q16 : bounds_alpha;
  assign ea_sat = (ewm_alpha > afst_pkg::ONE_Q16) ? afst_pkg::ONE_Q16 : ewm_alpha;

  assign in_ch.ready  = (state == afst_pkg::ST_IDLE);
  assign out_ch.valid = res_valid;
  assign out_ch.score = res_score;

  // Load the result register when the finished score finds it free
  assign res_load = (state == afst_pkg::ST_OUT) && (!res_valid || out_ch.ready);

  // Pick the multiplier operands for the current step
  always_comb begin
    mul_a = ba;
    mul_b = '0;
    unique case (state)
      afst_pkg::ST_SHARP: begin
        mul_a = ba;
        mul_b = (sample > sharp_bound) ? (sample - sharp_bound) : '0;
      end
      afst_pkg::ST_BLUR: begin
        mul_a = ba;
        mul_b = (sample < blur_bound) ? (blur_bound - sample) : '0;
      end
      afst_pkg::ST_MIX1: begin
        mul_a = ea;
        mul_b = {{(afst_pkg::SAMPLE_W - afst_pkg::SCORE_W){1'b0}}, raw};
      end
      afst_pkg::ST_MIX2: begin
        mul_a = afst_pkg::ONE_Q16 - ea;
        mul_b = {{(afst_pkg::SAMPLE_W - afst_pkg::SCORE_W){1'b0}}, smoothed_score};
      end
      afst_pkg::ST_IDLE, afst_pkg::ST_APPLY, afst_pkg::ST_PREP, afst_pkg::ST_DIV,
      afst_pkg::ST_MIX3, afst_pkg::ST_OUT: begin
        mul_a = ba;
        mul_b = '0;
      end
      default: begin
        mul_a = ba;
        mul_b = '0;
      end
    endcase
  end

  // Range floor at 1.0 and numerator for the divide
  always_comb begin
    span = {1'b0, sharp_bound} - {1'b0, blur_bound};
    if (span[afst_pkg::SAMPLE_W] || (span[afst_pkg::SAMPLE_W-1:0] < afst_pkg::ONE_Q8)) begin
      range_next = afst_pkg::ONE_Q8;
    end else begin
      range_next = span[afst_pkg::SAMPLE_W-1:0];
    end
    num = sample - blur_bound;
  end

  // One restoring divide step
  always_comb begin
    rem_sh   = {rem, 1'b0};
    rem_ge   = (rem_sh >= {1'b0, range});
    rem_next = rem_ge ? afst_pkg::SAMPLE_W'(rem_sh - {1'b0, range})
                      : rem_sh[afst_pkg::SAMPLE_W-1:0];
  end

  assign mix_sum = acc + prod[afst_pkg::SUM_W-1:0];

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod <= {{afst_pkg::SAMPLE_W{1'b0}}, mul_a} * {{afst_pkg::ALPHA_W{1'b0}}, mul_b};
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bounds_alpha <= afst_pkg::BOUNDS_ALPHA_RST;
      ewm_alpha    <= afst_pkg::EWM_ALPHA_RST;
      sharp_start  <= afst_pkg::SHARP_START_RST;
      blur_start   <= afst_pkg::BLUR_START_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afst_pkg::REG_BOUNDS_ALPHA: bounds_alpha <= cfg_wdata[afst_pkg::ALPHA_W-1:0];
        afst_pkg::REG_EWM_ALPHA:    ewm_alpha    <= cfg_wdata[afst_pkg::ALPHA_W-1:0];
        afst_pkg::REG_SHARP_START:  sharp_start  <= cfg_wdata;
        afst_pkg::REG_BLUR_START:   blur_start   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result register: load a finished score, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_score <= '0;
    end else if (res_load) begin
      res_valid <= 1'b1;
      res_score <= smoothed_score;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= afst_pkg::ST_IDLE;
      sharp_bound    <= afst_pkg::SHARP_START_RST;
      blur_bound     <= afst_pkg::BLUR_START_RST;
      smoothed_score <= '0;
    end else begin
      unique case (state)
        afst_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            sample    <= in_ch.lap_std;
            ba        <= ba_sat;
            ea        <= ea_sat;
            is_update <= (afst_pkg::mode_t'(in_ch.mode) == afst_pkg::MODE_UPDATE);
            unique case (afst_pkg::mode_t'(in_ch.mode))
              afst_pkg::MODE_UPDATE: state <= afst_pkg::ST_SHARP;
              afst_pkg::MODE_DECAY: state <= afst_pkg::ST_MIX2;
              afst_pkg::MODE_RESET: begin
                sharp_bound    <= sharp_start;
                blur_bound     <= blur_start;
                smoothed_score <= '0;
                state          <= afst_pkg::ST_OUT;
              end
              afst_pkg::MODE_NONE: state <= afst_pkg::ST_OUT;
              default: state <= afst_pkg::ST_OUT;
            endcase
          end
        end
        afst_pkg::ST_SHARP: state <= afst_pkg::ST_BLUR;
        afst_pkg::ST_BLUR: begin
          sharp_bound <= sharp_bound + prod[afst_pkg::PROD_W-2:16];
          state       <= afst_pkg::ST_APPLY;
        end
        afst_pkg::ST_APPLY: begin
          blur_bound <= blur_bound - prod[afst_pkg::PROD_W-2:16];
          state      <= afst_pkg::ST_PREP;
        end
        afst_pkg::ST_PREP: begin
          range   <= range_next;
          rem     <= num;
          quot    <= '0;
          div_cnt <= '0;
          // Sample at or below the blur bound, or past the full range
          if (sample <= blur_bound) begin
            raw   <= '0;
            state <= afst_pkg::ST_MIX1;
          end else if (num >= range_next) begin
            raw   <= afst_pkg::ONE_Q16;
            state <= afst_pkg::ST_MIX1;
          end else begin
            state <= afst_pkg::ST_DIV;
          end
        end
        afst_pkg::ST_DIV: begin
          rem     <= rem_next;
          quot    <= {quot[afst_pkg::QUOT_W-2:0], rem_ge};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(afst_pkg::QUOT_W - 1)) begin
            raw   <= {1'b0, quot[afst_pkg::QUOT_W-2:0], rem_ge};
            state <= afst_pkg::ST_MIX1;
          end
        end
        afst_pkg::ST_MIX1: state <= afst_pkg::ST_MIX2;
        afst_pkg::ST_MIX2: begin
          acc   <= is_update ? prod[afst_pkg::SUM_W-1:0] : '0;
          state <= afst_pkg::ST_MIX3;
        end
        afst_pkg::ST_MIX3: begin
          smoothed_score <= mix_sum[afst_pkg::SUM_W-1:16];
          state          <= afst_pkg::ST_OUT;
        end
        afst_pkg::ST_OUT: begin
          // Hold until the result register is free
          if (res_load) begin
            state <= afst_pkg::ST_IDLE;
          end
        end
        default: state <= afst_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/afst_checker.sv @@
// Port-level checker for the focus score tracker, bound to the top level.
// Depends on afst_pkg and adaptive_focus_score_tracker_assert.svh.
`include "adaptive_focus_score_tracker_assert.svh"

module afst_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [afst_pkg::SCORE_W-1:0]   score
);

  // One item at a time: busy right after a transfer in
  `AFST_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

  // A fresh result appears exactly as the sequencer returns to idle
  `AFST_ASSERT_SAME(a_result_at_idle, $rose(out_valid), in_ready)

  // Score never exceeds one
  `AFST_ASSERT_SAME(a_score_range, out_valid, score <= afst_pkg::ONE_Q16)

  // Stalled result holds
  `AFST_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(score))

endmodule

bind adaptive_focus_score_tracker afst_checker u_afst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .score     (out_ch.score)
);
